// ===== hdl/kbpr_pkg.sv =====
// Package: shared constants, types and key encoding for the keypad bus packet responder.
`timescale 1ns / 1ps

package kbpr_pkg;

    // Sizing
    localparam int MAX_PACKET = 40;
    localparam int KEY_DEPTH  = 8;
    localparam int LEN_W      = $clog2(MAX_PACKET + 1);
    localparam int QPTR_W     = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int QCNT_W     = $clog2(KEY_DEPTH + 1);

    // Header bits and reply constants
    localparam int            ACK_BIT   = 2;
    localparam int            WARN_BIT  = 2;
    localparam int            ALARM_BIT = 1;
    localparam logic [7:0]    H1_BASE   = 8'h02;
    localparam logic [7:0]    NO_KEY    = 8'hFF;

    // Request operations
    typedef enum logic {
        OP_RX  = 1'b0,
        OP_KEY = 1'b1
    } op_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_REPLY   = 3'd0,
        ST_OTHER   = 3'd1,
        ST_CSUM    = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_KEYDROP = 3'd4
    } status_t;

    // One computed result group: a single status result or a four-byte reply
    typedef struct packed {
        status_t     status;
        logic        multi;
        logic [7:0]  h1;
        logic [7:0]  h2;
        logic [7:0]  csum;
        logic        warn_rise;
        logic        alarm_rise;
        logic        warn_now;
        logic        alarm_now;
    } res_bundle_t;

    // Key character to 4-bit key code
    function automatic logic [3:0] encode_key(input logic [7:0] k);
        logic [3:0] code;
        code = 4'h0;
        if (k >= 8'h31 && k <= 8'h39) code = k[3:0];
        else if (k == 8'h30) code = 4'ha;
        else if (k == 8'h66 || k == 8'h2a) code = 4'hb;
        else if (k == 8'h76 || k == 8'h23) code = 4'hc;
        else if (k == 8'h70) code = 4'hd;
        else if (k == 8'h78 || k == 8'h3b || k == 8'h6e || k == 8'h4e) code = 4'he;
        else if (k == 8'h0d || k == 8'h2b || k == 8'h79 || k == 8'h59) code = 4'hf;
        return code;
    endfunction

endpackage

// ===== hdl/keypad_bus_packet_responder_unit.sv =====
// Top level: input register, device ID register, core, key queue and result register.
//
//  channel   | handshake            | payload
//  ----------+----------------------+------------------------------------------------
//  in        | in_valid / in_ready  | operation, data_byte
//  out       | out_valid / out_ready| status, reply_byte, warning_rise, alarm_rise,
//            |                      | warning_now, alarm_now, last
//  cfg       | cfg_wen              | cfg_wdata (device_id)
//
// A request is processed while it is held in the input register; its first result is
// on the output from the edge that takes the request out of the input register.
// A request with no result leaves the input register without waiting on the output; a reply
// is four results, one per output handshake, sent from the single result register.
// A request that gives results waits while the result register holds an unfinished
// group, and in_ready stays low meanwhile. Reset clears control state, not queue contents.
`timescale 1ns / 1ps

module keypad_bus_packet_responder_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       operation,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] status,
    output logic [7:0] reply_byte,
    output logic       warning_rise,
    output logic       alarm_rise,
    output logic       warning_now,
    output logic       alarm_now,
    output logic       last,
    input  logic       cfg_wen,
    input  logic [3:0] cfg_wdata
);
    import kbpr_pkg::*;

    logic        in_valid_reg, in_valid_next;
    op_t         op_reg;
    logic [7:0]  data_reg;
    logic [3:0]  dev_id_reg;

    logic        advance;
    logic        has_result;
    logic        can_load;
    res_bundle_t bundle;
    logic        q_push, q_pop, q_empty, q_full;
    logic [7:0]  q_rdata;

    // Input register control
    assign advance       = in_valid_reg && (!has_result || can_load);
    assign in_ready      = !in_valid_reg || advance;
    assign in_valid_next = in_ready ? in_valid : in_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            dev_id_reg   <= 4'h0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (cfg_wen)
            begin
                dev_id_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg   <= op_t'(operation);
            data_reg <= data_byte;
        end
    end

    // Packet and key processing
    kbpr_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (in_valid_reg),
        .fire       (advance),
        .op         (op_reg),
        .rx         (data_reg),
        .device_id  (dev_id_reg),
        .q_rdata    (q_rdata),
        .q_empty    (q_empty),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_pop      (q_pop),
        .has_result (has_result),
        .result     (bundle)
    );

    // Key press queue
    kbpr_key_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .pop   (q_pop),
        .wdata (data_reg),
        .rdata (q_rdata),
        .empty (q_empty),
        .full  (q_full)
    );

    // Result register
    kbpr_out_buf u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance && has_result),
        .bundle       (bundle),
        .can_load     (can_load),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .reply_byte   (reply_byte),
        .warning_rise (warning_rise),
        .alarm_rise   (alarm_rise),
        .warning_now  (warning_now),
        .alarm_now    (alarm_now),
        .last         (last)
    );

endmodule

// ===== hdl/kbpr_key_queue.sv =====
// Key press queue: circular buffer of key characters with count.
`timescale 1ns / 1ps

module kbpr_key_queue (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic       pop,
    input  logic [7:0] wdata,
    output logic [7:0] rdata,
    output logic       empty,
    output logic       full
);
    import kbpr_pkg::*;

    logic [7:0]        mem [KEY_DEPTH];
    logic [QPTR_W-1:0] head_reg, head_next;
    logic [QPTR_W-1:0] tail_reg, tail_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic [7:0]        head_data_reg;

    // Status and oldest entry
    assign empty = (count_reg == '0);
    assign full  = (count_reg == QCNT_W'(KEY_DEPTH));
    assign rdata = head_data_reg;

    // Pointer and count update
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
        begin
            tail_next  = (tail_reg == QPTR_W'(KEY_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
        else if (pop)
        begin
            head_next  = (head_reg == QPTR_W'(KEY_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Storage, no reset; the oldest entry is kept in a register
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[tail_reg] <= wdata;
        end
        if (push && empty)
        begin
            head_data_reg <= wdata;
        end
        else if (pop)
        begin
            head_data_reg <= mem[head_next];
        end
    end

endmodule

// ===== hdl/kbpr_core.sv =====
// Packet framing, checksum, flag tracking and reply formation for one request.
`timescale 1ns / 1ps

module kbpr_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  logic                 fire,
    input  kbpr_pkg::op_t        op,
    input  logic [7:0]           rx,
    input  logic [3:0]           device_id,
    input  logic [7:0]           q_rdata,
    input  logic                 q_empty,
    input  logic                 q_full,
    output logic                 q_push,
    output logic                 q_pop,
    output logic                 has_result,
    output kbpr_pkg::res_bundle_t result
);
    import kbpr_pkg::*;

    logic             recv_reg, recv_next;
    logic             pzero_reg, pzero_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       lastb_reg, lastb_next;
    logic [7:0]       hf_reg, hf_next;
    logic [7:0]       hs_reg, hs_next;
    logic             warn_reg, warn_next;
    logic             alarm_reg, alarm_next;
    logic [7:0]       pkey_reg, pkey_next;

    logic [LEN_W-1:0] len_inc;
    logic [7:0]       cs;
    logic             wnew, anew;
    logic [7:0]       h1, h2, key;

    assign len_inc = len_reg + 1'b1;
    assign cs      = (sum_reg == 8'h00) ? 8'h01 : sum_reg;
    assign wnew    = hs_reg[WARN_BIT];
    assign anew    = hs_reg[ALARM_BIT];
    assign h1      = {device_id, 4'h0} + H1_BASE;
    assign key     = q_empty ? NO_KEY : q_rdata;

    // Next state and result for the request in the input register
    always_comb
    begin
        recv_next  = recv_reg;
        pzero_next = pzero_reg;
        len_next   = len_reg;
        sum_next   = sum_reg;
        lastb_next = lastb_reg;
        hf_next    = hf_reg;
        hs_next    = hs_reg;
        warn_next  = warn_reg;
        alarm_next = alarm_reg;
        pkey_next  = pkey_reg;
        q_push     = 1'b0;
        q_pop      = 1'b0;
        has_result = 1'b0;
        h2         = 8'h00;
        result     = '0;

        if (req_valid)
        begin
            if (op == OP_KEY)
            begin
                if (q_full)
                begin
                    has_result = 1'b1;
                    result.status = ST_KEYDROP;
                end
                else
                begin
                    q_push = fire;
                end
            end
            else if (!recv_reg)
            begin
                // idle: a nonzero byte after a zero opens a packet
                if (pzero_reg && rx != 8'h00)
                begin
                    recv_next  = 1'b1;
                    len_next   = LEN_W'(1);
                    hf_next    = rx;
                    hs_next    = 8'h00;
                    sum_next   = 8'h00;
                    lastb_next = rx;
                end
                pzero_next = (rx == 8'h00);
            end
            else
            begin
                pzero_next = (rx == 8'h00);
                len_next   = len_inc;
                if (len_inc == LEN_W'(2))
                begin
                    hs_next = rx;
                end
                if (rx != 8'h00)
                begin
                    if (len_inc >= LEN_W'(MAX_PACKET))
                    begin
                        recv_next = 1'b0;
                        has_result = 1'b1;
                        result.status = ST_OVERFLOW;
                    end
                    else
                    begin
                        sum_next   = sum_reg + lastb_reg;
                        lastb_next = rx;
                    end
                end
                else
                begin
                    // terminator
                    recv_next  = 1'b0;
                    has_result = 1'b1;
                    if (cs != lastb_reg)
                    begin
                        result.status = ST_CSUM;
                    end
                    else
                    begin
                        warn_next  = wnew;
                        alarm_next = anew;
                        result.warn_rise  = wnew && !warn_reg;
                        result.alarm_rise = anew && !alarm_reg;
                        if (hf_reg[7:4] == device_id)
                        begin
                            if (hf_reg[ACK_BIT])
                            begin
                                q_pop = fire && !q_empty;
                                h2 = (key != NO_KEY) ? {encode_key(key), 4'h0} : 8'h00;
                                pkey_next = h2;
                            end
                            else
                            begin
                                h2 = (pkey_reg == NO_KEY) ? 8'h00 : pkey_reg;
                            end
                            result.status = ST_REPLY;
                            result.multi  = 1'b1;
                            result.h1     = h1;
                            result.h2     = h2;
                            result.csum   = h1 + h2;
                        end
                        else
                        begin
                            result.status = ST_OTHER;
                        end
                    end
                end
            end
        end
        result.warn_now  = warn_next;
        result.alarm_now = alarm_next;
    end

    // State advances only when the request is taken from the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recv_reg  <= 1'b0;
            pzero_reg <= 1'b0;
            len_reg   <= '0;
            sum_reg   <= 8'h00;
            lastb_reg <= 8'h00;
            hf_reg    <= 8'h00;
            hs_reg    <= 8'h00;
            warn_reg  <= 1'b0;
            alarm_reg <= 1'b0;
            pkey_reg  <= NO_KEY;
        end
        else if (fire)
        begin
            recv_reg  <= recv_next;
            pzero_reg <= pzero_next;
            len_reg   <= len_next;
            sum_reg   <= sum_next;
            lastb_reg <= lastb_next;
            hf_reg    <= hf_next;
            hs_reg    <= hs_next;
            warn_reg  <= warn_next;
            alarm_reg <= alarm_next;
            pkey_reg  <= pkey_next;
        end
    end

endmodule

// ===== hdl/kbpr_out_buf.sv =====
// Result register: holds one result group and sends it out one result per handshake.
`timescale 1ns / 1ps

module kbpr_out_buf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  kbpr_pkg::res_bundle_t bundle,
    output logic                  can_load,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [2:0]            status,
    output logic [7:0]            reply_byte,
    output logic                  warning_rise,
    output logic                  alarm_rise,
    output logic                  warning_now,
    output logic                  alarm_now,
    output logic                  last
);
    import kbpr_pkg::*;

    res_bundle_t bundle_reg;
    logic        valid_reg, valid_next;
    logic [1:0]  idx_reg, idx_next;
    logic [7:0]  sel_byte;

    // Current result
    assign last      = !bundle_reg.multi || (idx_reg == 2'd3);
    assign out_valid = valid_reg;
    assign can_load  = !valid_reg || (out_ready && last);

    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_byte = bundle_reg.h1;
            2'd1:    sel_byte = bundle_reg.h2;
            2'd2:    sel_byte = 8'h00;
            2'd3:    sel_byte = bundle_reg.csum;
            default: sel_byte = 8'h00;
        endcase
    end

    assign status       = bundle_reg.status;
    assign reply_byte   = bundle_reg.multi ? sel_byte : 8'h00;
    assign warning_rise = bundle_reg.warn_rise;
    assign alarm_rise   = bundle_reg.alarm_rise;
    assign warning_now  = bundle_reg.warn_now;
    assign alarm_now    = bundle_reg.alarm_now;

    // Valid and index sequencing
    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = 2'd0;
        end
        else if (valid_reg && out_ready)
        begin
            if (last)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bundle_reg <= bundle;
        end
    end

endmodule

// ===== verif/keypad_bus_packet_responder_unit_tb.sv =====
// Testbench: random and directed bus packets and key presses, checked against an internal predictor.
`timescale 1ns / 1ps

module keypad_bus_packet_responder_unit_tb;

    import kbpr_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_CYCLS = 12;

    // One request for the input channel
    typedef struct {
        op_t        op;
        logic [7:0] data;
    } bus_req_t;

    // One predicted result
    typedef struct {
        status_t    status;
        logic [7:0] reply;
        logic       warn_rise;
        logic       alarm_rise;
        logic       warn_now;
        logic       alarm_now;
        logic       last;
    } resp_rec_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       operation;
    logic [7:0] data_byte;
    logic       out_valid;
    logic       out_ready;
    logic [2:0] status;
    logic [7:0] reply_byte;
    logic       warning_rise;
    logic       alarm_rise;
    logic       warning_now;
    logic       alarm_now;
    logic       last;
    logic       cfg_wen;
    logic [3:0] cfg_wdata;

    keypad_bus_packet_responder_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .reply_byte   (reply_byte),
        .warning_rise (warning_rise),
        .alarm_rise   (alarm_rise),
        .warning_now  (warning_now),
        .alarm_now    (alarm_now),
        .last         (last),
        .cfg_wen      (cfg_wen),
        .cfg_wdata    (cfg_wdata)
    );

    // Stimulus and scoreboard storage
    bus_req_t  pending_reqs[$];
    resp_rec_t expected_resps[$];

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  n_queued       = 0;
    int  n_accepted     = 0;
    int  n_checked      = 0;
    int  n_cfg_writes   = 0;
    int  in_idle_pct    = 0;
    int  out_stall_pct  = 0;
    int  gap_left       = 0;
    int  stall_left     = 0;
    bit  req_taken      = 0;

    // Predictor state
    bit         in_packet   = 0;
    bit         zero_seen   = 0;
    int         pkt_len     = 0;
    logic [7:0] byte_sum    = '0;
    logic [7:0] final_byte  = '0;
    logic [7:0] hdr0        = '0;
    logic [7:0] hdr1        = '0;
    logic       warn_flag   = 0;
    logic       alarm_flag  = 0;
    logic [7:0] held_code   = NO_KEY;
    logic [7:0] key_fifo[$];
    logic [3:0] model_dev_id = '0;

    // Clock
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Key character to keypad code
    function automatic logic [3:0] key_code(input logic [7:0] ch);
        if (ch >= "1" && ch <= "9")
            return ch[3:0];
        case (ch)
            "0":                return 4'ha;
            "f", "*":           return 4'hb;
            "v", "#":           return 4'hc;
            "p":                return 4'hd;
            "x", ";", "n", "N": return 4'he;
            8'h0d, "+", "y", "Y": return 4'hf;
            default:            return 4'h0;
        endcase
    endfunction

    function automatic void expect_resp(input status_t st, input logic [7:0] rb,
                                        input logic wr, input logic ar, input logic lst);
        resp_rec_t r;
        r.status     = st;
        r.reply      = rb;
        r.warn_rise  = wr;
        r.alarm_rise = ar;
        r.warn_now   = warn_flag;
        r.alarm_now  = alarm_flag;
        r.last       = lst;
        expected_resps.push_back(r);
    endfunction

    // Predict the results of one accepted request
    function automatic void predict_request(input op_t op, input logic [7:0] rx);
        logic [7:0] cs;
        logic [7:0] h1;
        logic [7:0] h2;
        logic [7:0] popped;
        logic       wnew;
        logic       anew;
        logic       wr;
        logic       ar;
        // key push
        if (op == OP_KEY)
        begin
            if (key_fifo.size() >= KEY_DEPTH)
                expect_resp(ST_KEYDROP, 8'h00, 0, 0, 1);
            else
                key_fifo.push_back(rx);
            return;
        end
        // waiting for a packet start
        if (!in_packet)
        begin
            if (zero_seen)
            begin
                if (rx == 8'h00)
                    return;
                in_packet  = 1;
                pkt_len    = 1;
                hdr0       = rx;
                hdr1       = 8'h00;
                byte_sum   = 8'h00;
                final_byte = rx;
            end
            zero_seen = (rx == 8'h00);
            return;
        end
        zero_seen = (rx == 8'h00);
        pkt_len++;
        if (pkt_len == 2)
            hdr1 = rx;
        // data byte or overflow
        if (rx != 8'h00)
        begin
            if (pkt_len >= MAX_PACKET)
            begin
                in_packet = 0;
                expect_resp(ST_OVERFLOW, 8'h00, 0, 0, 1);
                return;
            end
            byte_sum   = byte_sum + final_byte;
            final_byte = rx;
            return;
        end
        // terminator: checksum, flags, reply
        in_packet = 0;
        cs = (byte_sum == 8'h00) ? 8'h01 : byte_sum;
        if (cs != final_byte)
        begin
            expect_resp(ST_CSUM, 8'h00, 0, 0, 1);
            return;
        end
        wnew       = hdr1[WARN_BIT];
        anew       = hdr1[ALARM_BIT];
        wr         = wnew && !warn_flag;
        ar         = anew && !alarm_flag;
        warn_flag  = wnew;
        alarm_flag = anew;
        if (hdr0[7:4] != model_dev_id)
        begin
            expect_resp(ST_OTHER, 8'h00, wr, ar, 1);
            return;
        end
        h1 = {model_dev_id, 4'h2};
        if (hdr0[ACK_BIT])
        begin
            popped = (key_fifo.size() > 0) ? key_fifo.pop_front() : NO_KEY;
            h2 = (popped == NO_KEY) ? 8'h00 : {key_code(popped), 4'h0};
            held_code = h2;
        end
        else
            h2 = (held_code == NO_KEY) ? 8'h00 : held_code;
        expect_resp(ST_REPLY, h1, wr, ar, 0);
        expect_resp(ST_REPLY, h2, wr, ar, 0);
        expect_resp(ST_REPLY, 8'h00, wr, ar, 0);
        expect_resp(ST_REPLY, h1 + h2, wr, ar, 1);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR cycle %0d: %s got %0d, expected %0d", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // Request driver: changes on the falling edge
    always @(negedge clk)
    begin
        bus_req_t r;
        if (!rst_n)
            in_valid <= 0;
        else if (!(in_valid && !req_taken))
        begin
            req_taken = 0;
            if (gap_left > 0)
            begin
                in_valid <= 0;
                gap_left--;
            end
            else if (pending_reqs.size() > 0)
            begin
                r = pending_reqs.pop_front();
                in_valid  <= 1;
                operation <= r.op;
                data_byte <= r.data;
                if ($urandom_range(0, 99) < in_idle_pct)
                    gap_left = $urandom_range(1, 7);
            end
            else
                in_valid <= 0;
        end
    end

    // Result-side back-pressure
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1;
            if ($urandom_range(0, 99) < out_stall_pct)
                stall_left = $urandom_range(1, 7);
        end
    end

    // Monitor: sample handshakes on the rising edge
    always @(posedge clk)
    begin
        resp_rec_t e;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predict_request(op_t'(operation), data_byte);
                req_taken = 1;
                n_accepted++;
            end
            if (out_valid && out_ready)
            begin
                if (expected_resps.size() == 0)
                    report_mismatch("unexpected result, status", status, -1);
                else
                begin
                    e = expected_resps.pop_front();
                    n_checked++;
                    if (status !== e.status)
                        report_mismatch("status", status, e.status);
                    if (reply_byte !== e.reply)
                        report_mismatch("reply_byte", reply_byte, e.reply);
                    if (warning_rise !== e.warn_rise)
                        report_mismatch("warning_rise", warning_rise, e.warn_rise);
                    if (alarm_rise !== e.alarm_rise)
                        report_mismatch("alarm_rise", alarm_rise, e.alarm_rise);
                    if (warning_now !== e.warn_now)
                        report_mismatch("warning_now", warning_now, e.warn_now);
                    if (alarm_now !== e.alarm_now)
                        report_mismatch("alarm_now", alarm_now, e.alarm_now);
                    if (last !== e.last)
                        report_mismatch("last", last, e.last);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout with %0d results outstanding", expected_resps.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Stimulus helpers
    task automatic push_req(input op_t op, input logic [7:0] d);
        bus_req_t r;
        r.op   = op;
        r.data = d;
        pending_reqs.push_back(r);
        n_queued++;
    endtask

    // Leading zeros, ndata nonzero data bytes (checksum last), terminator
    task automatic push_packet(input logic [3:0] addr, input bit ack, input int ndata,
                               input bit bad_sum);
        logic [7:0] sum;
        logic [7:0] b;
        logic [7:0] cs;
        int         i;
        int         nz;
        sum = 8'h00;
        nz  = $urandom_range(1, 3);
        for (i = 0; i < nz; i++)
            push_req(OP_RX, 8'h00);
        for (i = 0; i < ndata - 1; i++)
        begin
            if (i == 0)
            begin
                b = {addr, 4'($urandom_range(0, 15))};
                b[ACK_BIT] = ack;
                if (b == 8'h00)
                    b = 8'h01;
            end
            else
                b = 8'($urandom_range(1, 255));
            sum = sum + b;
            push_req(OP_RX, b);
        end
        cs = (ndata == 1) ? 8'h01 : ((sum == 8'h00) ? 8'h01 : sum);
        if (bad_sum)
        begin
            b = 8'($urandom_range(1, 255));
            while (b == cs)
                b = 8'($urandom_range(1, 255));
            cs = b;
        end
        push_req(OP_RX, cs);
        push_req(OP_RX, 8'h00);
    endtask

    task automatic push_overflow();
        int i;
        push_req(OP_RX, 8'h00);
        for (i = 0; i < MAX_PACKET; i++)
            push_req(OP_RX, 8'($urandom_range(1, 255)));
    endtask

    task automatic push_random_key();
        string charset;
        int    pick;
        charset = "1234567890f*v#px;nN+yY";
        pick = $urandom_range(0, 99);
        if (pick < 70)
            push_req(OP_KEY, charset[$urandom_range(0, charset.len() - 1)]);
        else if (pick < 78)
            push_req(OP_KEY, 8'h0d);
        else if (pick < 86)
            push_req(OP_KEY, NO_KEY);
        else
            push_req(OP_KEY, 8'($urandom_range(0, 255)));
    endtask

    // One random chunk of traffic, mostly well-formed packets
    task automatic push_random_chunk();
        int         pick;
        int         len_pick;
        int         n;
        int         i;
        logic [3:0] addr;
        pick = $urandom_range(0, 99);
        addr = ($urandom_range(0, 99) < 75) ? model_dev_id : 4'($urandom_range(0, 15));
        len_pick = $urandom_range(0, 99);
        if (len_pick < 5)
            n = 1;
        else if (len_pick < 10)
            n = $urandom_range(20, MAX_PACKET - 1);
        else
            n = $urandom_range(2, 8);
        if (pick < 55)
            push_packet(addr, 1'($urandom_range(0, 1)), n, 0);
        else if (pick < 67)
            push_packet(addr, 1'($urandom_range(0, 1)), $urandom_range(2, 8), 1);
        else if (pick < 84)
        begin
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++)
                push_random_key();
        end
        else if (pick < 92)
        begin
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++)
                push_req(OP_RX, 8'($urandom_range(0, 255)));
        end
        else if (pick < 95)
            push_overflow();
        else
        begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++)
                push_req(OP_RX, 8'h00);
        end
    endtask

    // Hold off until the block has gone quiet
    task automatic wait_quiet();
        do
            @(posedge clk);
        while (!(pending_reqs.size() == 0 && !in_valid && expected_resps.size() == 0));
        repeat (SETTLE_CYCLS) @(posedge clk);
    endtask

    task automatic write_dev_id(input logic [3:0] id);
        @(negedge clk);
        cfg_wen   <= 1;
        cfg_wdata <= id;
        @(negedge clk);
        cfg_wen   <= 0;
        model_dev_id = id;
        n_cfg_writes++;
    endtask

    // Main sequence
    initial
    begin
        logic [7:0] directed_bytes[$];
        int         ph;
        int         target;
        int         i;
        logic [3:0] ids[5];
        in_valid  = 0;
        operation = 0;
        data_byte = 0;
        out_ready = 0;
        cfg_wen   = 0;
        cfg_wdata = 0;
        rst_n     = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;
        write_dev_id(4'h0);

        // Directed: idle zeros, terminator as second byte, ack pops a key,
        // 0xFF key, empty queue on ack, checksum error, another device
        out_stall_pct = 25;
        in_idle_pct   = 25;
        directed_bytes = '{8'h00, 8'h00, 8'h01, 8'h00};
        foreach (directed_bytes[j])
            push_req(OP_RX, directed_bytes[j]);
        push_req(OP_KEY, "5");
        push_req(OP_KEY, 8'hFF);
        directed_bytes = '{8'h04, 8'h06, 8'h0a, 8'h00,
                           8'h04, 8'h02, 8'h06, 8'h00,
                           8'h04, 8'h04, 8'h08, 8'h00,
                           8'h11, 8'h22, 8'h99, 8'h00,
                           8'h31, 8'h01, 8'h32, 8'h00};
        foreach (directed_bytes[j])
            push_req(OP_RX, directed_bytes[j]);
        wait_quiet();

        // Random phases over several device IDs; the last one runs flat out
        ids[0] = 4'hF;
        ids[1] = 4'($urandom_range(1, 14));
        ids[2] = 4'h0;
        ids[3] = 4'($urandom_range(1, 14));
        ids[4] = 4'hF;
        for (ph = 0; ph < 5; ph++)
        begin
            write_dev_id(ids[ph]);
            if (ph == 4)
            begin
                in_idle_pct   = 0;
                out_stall_pct = 0;
            end
            else
            begin
                in_idle_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(15, 45);
                out_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(15, 45);
            end
            // first phase: fill the key queue past full, overflow, longest good packet
            if (ph == 0)
            begin
                for (i = 0; i < KEY_DEPTH + 2; i++)
                    push_random_key();
                push_overflow();
                push_packet(model_dev_id, 1, MAX_PACKET - 1, 0);
            end
            target = n_queued + 6;
            while (n_queued < target)
                push_random_chunk();
            wait_quiet();
        end

        repeat (20) @(posedge clk);
        while (expected_resps.size() > 0)
        begin
            report_mismatch("missing result, status", -1, expected_resps[0].status);
            void'(expected_resps.pop_front());
        end
        $display("Run: %0d requests accepted, %0d results checked", n_accepted, n_checked);
        $display("Device ID written %0d times, key queue overflow and packet overflow hit",
                 n_cfg_writes);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/kbpr_pkg.sv
hdl/kbpr_key_queue.sv
hdl/kbpr_core.sv
hdl/kbpr_out_buf.sv
hdl/keypad_bus_packet_responder_unit.sv
verif/keypad_bus_packet_responder_unit_tb.sv
